// ===== rtl/core/fcsg_pkg.sv =====
// ----------------------------------------------------------------------------
// fcsg_pkg
// shared types, constants and the step-count table of the circle span generator
// ----------------------------------------------------------------------------
package fcsg_pkg;

   localparam int unsigned MaxRadius  = 31;
   localparam int unsigned QueueDepth = 2;

   typedef logic [15:0] coord_type;
   typedef logic [4:0]  radius_type;

   // one circle job as handed from the front part to the back part
   typedef struct packed {
      coord_type  center_x;
      coord_type  center_y;
      radius_type radius;
      logic [4:0] steps;
      logic [9:0] limit;
      coord_type  fill_color;
   } circle_type;

   // one span item
   typedef struct packed {
      coord_type x_start;
      coord_type x_end;
      coord_type row;
      coord_type color;
      logic      last;
   } span_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTER,
      ST_TEST,
      ST_OUT_MINUS,
      ST_IN_PLUS,
      ST_IN_MINUS,
      ST_DONE
   } seq_state_type;

   // radius*707/1000 + 1
   function automatic logic [4:0] steps_of(radius_type r);
      logic [4:0] s;
      unique case (r) inside
         5'd0, 5'd1:   s = 5'd1;
         5'd2:         s = 5'd2;
         5'd3, 5'd4:   s = 5'd3;
         5'd5:         s = 5'd4;
         5'd6, 5'd7:   s = 5'd5;
         5'd8:         s = 5'd6;
         5'd9:         s = 5'd7;
         5'd10, 5'd11: s = 5'd8;
         5'd12:        s = 5'd9;
         5'd13, 5'd14: s = 5'd10;
         5'd15:        s = 5'd11;
         5'd16:        s = 5'd12;
         5'd17, 5'd18: s = 5'd13;
         5'd19:        s = 5'd14;
         5'd20, 5'd21: s = 5'd15;
         5'd22:        s = 5'd16;
         5'd23, 5'd24: s = 5'd17;
         5'd25:        s = 5'd18;
         5'd26:        s = 5'd19;
         5'd27, 5'd28: s = 5'd20;
         5'd29:        s = 5'd21;
         5'd30, 5'd31: s = 5'd22;
         default:      s = 5'd1;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/core/filled_circle_span_generator.sv =====
// ----------------------------------------------------------------------------
// filled_circle_span_generator
// turns circle requests into the horizontal spans that fill the disc
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake               payload
//  req      in   req_tvalid/req_tready   tdata: center_x, center_y, radius, fill_color
//  rsp      out  rsp_tvalid/rsp_tready   tdata: x_start, x_end, row, color; tlast: last
//
//  the back sequencer tries one span per cycle while a stalled output does not hold it
//  zero radius is taken and drops out in the front, no spans come out
//  synchronous active-high reset clears queue, sequencer and output register
//  the front keeps taking requests while the queue has room; a stalled
//    output only holds the back sequencer
//
module filled_circle_span_generator #(
   parameter int unsigned QUEUE_DEPTH = fcsg_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   // req item
   input  logic        req_tvalid,
   output logic        req_tready,
   // center_x [15:0], center_y [31:16], radius [36:32], fill_color [52:37], zero pad
   input  logic [55:0] req_tdata,
   // rsp item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // span_x_start [15:0], span_x_end [31:16], span_row [47:32], span_color [63:48]
   output logic [63:0] rsp_tdata,
   // last_span
   output logic        rsp_tlast
);
   import fcsg_pkg::*;

   queue_status_type queue_status;
   logic             queue_wr_en;
   logic             queue_rd_en;
   circle_type       queue_wr_data;
   circle_type       queue_rd_data;
   span_type         rsp_span;

   // front: clamp radius, derive step count and distance limit
   fcsg_front u_front (
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .queue_status  (queue_status),
      .queue_wr_en   (queue_wr_en),
      .queue_wr_data (queue_wr_data)
   );

   // job queue decoupling front from back
   fcsg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (queue_wr_en),
      .wr_data (queue_wr_data),
      .rd_en   (queue_rd_en),
      .rd_data (queue_rd_data),
      .status  (queue_status)
   );

   // back: span walk, one-span holdback for the last flag, output register
   fcsg_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_status  (queue_status),
      .queue_rd_data (queue_rd_data),
      .queue_rd_en   (queue_rd_en),
      .rsp_valid     (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_span      (rsp_span)
   );

   assign rsp_tdata = {rsp_span.color, rsp_span.row, rsp_span.x_end, rsp_span.x_start};
   assign rsp_tlast = rsp_span.last;

endmodule

// ===== rtl/core/fcsg_front.sv =====
// ----------------------------------------------------------------------------
// fcsg_front
// accepts circle requests, clamps the radius, works out step count and limit
// ----------------------------------------------------------------------------
module fcsg_front (
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [55:0]                req_tdata,
   input  fcsg_pkg::queue_status_type queue_status,
   output logic                       queue_wr_en,
   output fcsg_pkg::circle_type       queue_wr_data
);
   import fcsg_pkg::*;

   radius_type radius_raw;
   radius_type radius_sat;
   logic [9:0] radius_sq;

   always_comb begin
      radius_raw = req_tdata[36:32];
      radius_sat = (radius_raw > 5'(MaxRadius)) ? 5'(MaxRadius) : radius_raw;
      radius_sq  = {5'b0, radius_sat} * {5'b0, radius_sat};

      queue_wr_data.center_x   = req_tdata[15:0];
      queue_wr_data.center_y   = req_tdata[31:16];
      queue_wr_data.radius     = radius_sat;
      queue_wr_data.steps      = steps_of(radius_sat);
      queue_wr_data.limit      = radius_sq + {6'b0, radius_sat[4:1]};
      queue_wr_data.fill_color = req_tdata[52:37];
   end

   // zero radius is taken and dropped
   assign req_tready  = !queue_status.full;
   assign queue_wr_en = req_tvalid && !queue_status.full && (radius_sat != '0);

endmodule

// ===== rtl/core/fcsg_queue.sv =====
// ----------------------------------------------------------------------------
// fcsg_queue
// small register queue of circle jobs between front and back
// ----------------------------------------------------------------------------
module fcsg_queue #(
   parameter int unsigned DEPTH = fcsg_pkg::QueueDepth
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  fcsg_pkg::circle_type       wr_data,
   input  logic                       rd_en,
   output fcsg_pkg::circle_type       rd_data,
   output fcsg_pkg::queue_status_type status
);
   import fcsg_pkg::*;

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   circle_type        mem_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_wr, do_rd;

   always_comb begin
      status.full      = (count_ff == CntW'(DEPTH));
      status.not_empty = (count_ff != '0);
      do_wr = wr_en && !status.full;
      do_rd = rd_en && status.not_empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign rd_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/core/fcsg_back.sv =====
// ----------------------------------------------------------------------------
// fcsg_back
// span sequencer: walks one circle, holds one span back to mark the last one
// ----------------------------------------------------------------------------
module fcsg_back (
   input  logic                       clock,
   input  logic                       reset,
   input  fcsg_pkg::queue_status_type queue_status,
   input  fcsg_pkg::circle_type       queue_rd_data,
   output logic                       queue_rd_en,
   output logic                       rsp_valid,
   input  logic                       rsp_tready,
   output fcsg_pkg::span_type         rsp_span
);
   import fcsg_pkg::*;

   seq_state_type state_ff, state_in;
   circle_type    job_ff, job_in;
   logic [4:0]    idx_ff, idx_in;
   logic [4:0]    ext_ff, ext_in;
   span_type      held_ff, held_in;
   logic          held_valid_ff, held_valid_in;
   span_type      out_ff, out_in;
   logic          out_valid_ff, out_valid_in;

   logic [10:0]   dist_sq;
   logic          over, outer;
   logic [4:0]    ext_dec, idx_m1;
   logic          cand_on;
   coord_type     cand_start, cand_row;
   logic [5:0]    cand_len;
   logic          cand_fire, out_free, stall;
   span_type      cand;

   always_comb begin
      dist_sq = 11'({5'b0, idx_ff} * {5'b0, idx_ff}) +
                11'({5'b0, ext_ff} * {5'b0, ext_ff});
      over    = dist_sq > {1'b0, job_ff.limit};
      outer   = over && (ext_ff > job_ff.steps);
      ext_dec = (over && ext_ff != '0) ? ext_ff - 1'b1 : ext_ff;
      idx_m1  = idx_ff - 1'b1;

      out_free = !out_valid_ff || rsp_tready;

      state_in      = state_ff;
      job_in        = job_ff;
      idx_in        = idx_ff;
      ext_in        = ext_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      queue_rd_en   = 1'b0;

      cand_on    = 1'b0;
      cand_start = job_ff.center_x - 16'(ext_ff);
      cand_row   = job_ff.center_y;
      cand_len   = {ext_ff, 1'b0};

      unique case (state_ff)
         ST_IDLE: begin
            if (queue_status.not_empty) begin
               queue_rd_en = 1'b1;
               job_in      = queue_rd_data;
               state_in    = ST_CENTER;
            end
         end
         ST_CENTER: begin
            cand_on    = 1'b1;
            cand_start = job_ff.center_x - 16'(job_ff.radius);
            cand_len   = {job_ff.radius, 1'b0};
            idx_in     = 5'd1;
            ext_in     = job_ff.radius;
            state_in   = ST_TEST;
         end
         ST_TEST: begin
            cand_on = 1'b1;
            if (outer) begin
               cand_start = job_ff.center_x - 16'(idx_m1);
               cand_row   = job_ff.center_y + 16'(ext_ff);
               cand_len   = {idx_m1, 1'b0};
               state_in   = ST_OUT_MINUS;
            end else begin
               cand_start = job_ff.center_x - 16'(ext_dec);
               cand_row   = job_ff.center_y + 16'(idx_ff);
               cand_len   = {ext_dec, 1'b0};
               ext_in     = ext_dec;
               state_in   = ST_IN_MINUS;
            end
         end
         ST_OUT_MINUS: begin
            cand_on    = 1'b1;
            cand_start = job_ff.center_x - 16'(idx_m1);
            cand_row   = job_ff.center_y - 16'(ext_ff);
            cand_len   = {idx_m1, 1'b0};
            ext_in     = ext_ff - 1'b1;
            state_in   = ST_IN_PLUS;
         end
         ST_IN_PLUS: begin
            cand_on  = 1'b1;
            cand_row = job_ff.center_y + 16'(idx_ff);
            state_in = ST_IN_MINUS;
         end
         ST_IN_MINUS: begin
            cand_on  = 1'b1;
            cand_row = job_ff.center_y - 16'(idx_ff);
            if (idx_ff == job_ff.steps) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_TEST;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_in        = held_ff;
               out_in.last   = 1'b1;
               out_valid_in  = 1'b1;
               held_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      cand.x_start = cand_start;
      cand.x_end   = cand_start + 16'(cand_len) - 16'd1;
      cand.row     = cand_row;
      cand.color   = job_ff.fill_color;
      cand.last    = 1'b0;

      // zero-length spans are dropped; a kept span pushes out the one held
      cand_fire = cand_on && (cand_len != '0);
      stall     = cand_fire && held_valid_ff && !out_free;

      if (stall) begin
         state_in = state_ff;
         idx_in   = idx_ff;
         ext_in   = ext_ff;
      end else if (cand_fire) begin
         held_in       = cand;
         held_valid_in = 1'b1;
         if (held_valid_ff) begin
            out_in       = held_ff;
            out_in.last  = 1'b0;
            out_valid_in = 1'b1;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_span  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      idx_ff  <= idx_in;
      ext_ff  <= ext_in;
      held_ff <= held_in;
      out_ff  <= out_in;
   end

`ifndef SYNTH
   a_ext_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_CENTER) |-> ext_ff <= job_ff.radius)
      else $error("extent above radius");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEST || state_ff == ST_OUT_MINUS || state_ff == ST_IN_PLUS ||
       state_ff == ST_IN_MINUS) |-> (idx_ff != '0 && idx_ff <= job_ff.steps))
      else $error("row index out of range");

   a_done_held: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> held_valid_ff)
      else $error("circle finished with no span held");

   a_last_flush: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (out_valid_ff && out_ff.last))
      else $error("final span not flagged last");
`endif

endmodule

// ===== sim/fcsg_span_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsg_span_checker
// watches the request and span channels of the circle span generator,
// predicts the spans of every accepted circle and compares them in order
// ----------------------------------------------------------------------------
module fcsg_span_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // center_x, center_y, radius, fill_color, zero pad
   input  logic [55:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // span_x_start, span_x_end, span_row, span_color
   input  logic [63:0] rsp_tdata,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          spans_pending
);
   import fcsg_pkg::*;

   localparam int unsigned SpanLimit = 2 * MaxRadius + 1;
   localparam int          PrintLimit = 50;

   span_type expected_spans[$];
   int unsigned circle_span_count;

   initial begin
      fail_count    = 0;
      spans_pending = 0;
   end

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      // keep the log short when everything goes wrong
      if (fail_count < PrintLimit)
         $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic add_span(input coord_type start, input coord_type row,
                           input int unsigned len, input coord_type color);
      span_type s;
      if (len == 0 || circle_span_count >= SpanLimit)
         return;
      s.x_start = start;
      s.x_end   = 16'(start + len - 1);
      s.row     = row;
      s.color   = color;
      s.last    = 1'b0;
      expected_spans.push_back(s);
      circle_span_count++;
   endtask

   task automatic plan_circle_spans(input coord_type cx, input coord_type cy,
                                    input radius_type r, input coord_type color);
      int unsigned rad;
      int unsigned steps;
      int unsigned limit;
      int unsigned ext;
      span_type    tail;
      rad = r;
      if (rad > MaxRadius)
         rad = MaxRadius;
      circle_span_count = 0;
      if (rad == 0)
         return;
      steps = rad * 707 / 1000 + 1;
      limit = rad * rad + rad / 2;
      ext   = rad;
      // center row
      add_span(16'(cx - rad), cy, 2 * rad, color);
      for (int unsigned i = 1; i <= steps; i++) begin
         if (i * i + ext * ext > limit) begin
            // outer rows before the extent shrinks
            if (ext > steps) begin
               add_span(16'(cx - i + 1), 16'(cy + ext), 2 * (i - 1), color);
               add_span(16'(cx - i + 1), 16'(cy - ext), 2 * (i - 1), color);
            end
            if (ext > 0)
               ext--;
         end
         add_span(16'(cx - ext), 16'(cy + i), 2 * ext, color);
         add_span(16'(cx - ext), 16'(cy - i), 2 * ext, color);
      end
      if (circle_span_count > 0) begin
         tail = expected_spans.pop_back();
         tail.last = 1'b1;
         expected_spans.push_back(tail);
      end
   endtask

   always @(posedge clock) begin : watch
      span_type want;
      if (reset) begin
         expected_spans.delete();
      end else begin
         if (req_tvalid && req_tready)
            plan_circle_spans(req_tdata[15:0], req_tdata[31:16], req_tdata[36:32],
                              req_tdata[52:37]);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_spans.size() == 0) begin
               report_mismatch("span with none expected, x_start", rsp_tdata[15:0],
                               16'h0000);
            end else begin
               want = expected_spans.pop_front();
               if (rsp_tdata[15:0] !== want.x_start)
                  report_mismatch("x_start", rsp_tdata[15:0], want.x_start);
               if (rsp_tdata[31:16] !== want.x_end)
                  report_mismatch("x_end", rsp_tdata[31:16], want.x_end);
               if (rsp_tdata[47:32] !== want.row)
                  report_mismatch("row", rsp_tdata[47:32], want.row);
               if (rsp_tdata[63:48] !== want.color)
                  report_mismatch("color", rsp_tdata[63:48], want.color);
               if (rsp_tlast !== want.last)
                  report_mismatch("last", {15'b0, rsp_tlast}, {15'b0, want.last});
            end
         end
      end
      spans_pending <= expected_spans.size();
   end

endmodule

// ===== sim/tb_filled_circle_span_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_filled_circle_span_generator
// drives circle requests into the span generator with random gaps and
// stalls, lets the checker predict and compare the spans, gives the verdict
// ----------------------------------------------------------------------------
module tb_filled_circle_span_generator;
   import fcsg_pkg::*;

   localparam int CycleLimit  = 1_500_000;
   localparam int LongHold    = 400;
   localparam int DrainCycles = 200;
   localparam int MaxGap      = 8;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // center_x, center_y, radius, fill_color, zero pad
   logic [55:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // span_x_start, span_x_end, span_row, span_color
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;

   int fail_count;
   int spans_pending;

   // random gaps on both sides when set
   bit idle_on      = 1'b0;
   // asks the receiver for one long stall
   bit hold_request = 1'b0;

   filled_circle_span_generator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   fcsg_span_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .spans_pending (spans_pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs or spans go missing
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // one circle item: optional gap, then hold valid until accepted
   task automatic send_circle(input coord_type cx, input coord_type cy,
                              input radius_type r, input coord_type color);
      int gap;
      gap = idle_on ? $urandom_range(0, MaxGap) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, color, r, cy, cx};
      do @(posedge clock); while (!req_tready);
   endtask

   // coordinates cluster at both ends so the wrap is hit often
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom_range(0, 40));
         1:       return 16'(16'hffff - $urandom_range(0, 40));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random_circles(input int count);
      radius_type r;
      repeat (count) begin
         r = ($urandom_range(0, 9) == 0) ? 5'd0 : 5'($urandom_range(1, MaxRadius));
         send_circle(rand_coord(), rand_coord(), r, 16'($urandom));
      end
   endtask

   // the pending count is only trusted once the clock has advanced
   task automatic wait_for_drain();
      do @(posedge clock); while (spans_pending != 0);
   endtask

   // receiver: per item a random stall while gaps are on, or one long stall on request
   initial begin : receiver
      int wait_cycles;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            wait_cycles  = LongHold;
            hold_request = 1'b0;
         end else begin
            wait_cycles = idle_on ? $urandom_range(0, MaxGap) : 0;
         end
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero radius, smallest and largest radius, wrap at both ends
      send_circle(16'h0100, 16'h0100, 5'd0,  16'h1234);
      send_circle(16'h0100, 16'h0100, 5'd1,  16'hffff);
      send_circle(16'h0100, 16'h0100, 5'd2,  16'h0000);
      send_circle(16'h0100, 16'h0100, 5'd3,  16'ha5a5);
      send_circle(16'h8000, 16'h8000, 5'd31, 16'hf800);
      send_circle(16'h0000, 16'h0000, 5'd31, 16'h07e0);
      send_circle(16'hffff, 16'hffff, 5'd31, 16'h001f);
      send_circle(16'h0000, 16'hffff, 5'd16, 16'hffff);
      send_circle(16'hffff, 16'h0000, 5'd5,  16'h0000);
      send_circle(16'h0000, 16'h0000, 5'd0,  16'hffff);
      send_circle(16'hffff, 16'hffff, 5'd0,  16'hffff);
      send_circle(16'hffff, 16'hffff, 5'd31, 16'hffff);
      send_circle(16'h0000, 16'h0000, 5'd1,  16'h0000);
      send_circle(16'h0003, 16'h0002, 5'd30, 16'h5a5a);
      send_circle(16'h1000, 16'h2000, 5'd4,  16'h0f0f);
      send_circle(16'h1000, 16'h2000, 5'd7,  16'hf0f0);
      send_circle(16'h1000, 16'h2000, 5'd8,  16'h3c3c);
      send_circle(16'h1000, 16'h2000, 5'd10, 16'hc3c3);
      send_circle(16'h7fff, 16'h8001, 5'd15, 16'h8000);
      send_circle(16'h0001, 16'hfffe, 5'd24, 16'h0001);
      req_tvalid <= 1'b0;
      wait_for_drain();

      idle_on = 1'b1;
      send_random_circles(200);

      // long receiver stall while big circles keep coming, input must back up
      idle_on      = 1'b0;
      hold_request = 1'b1;
      repeat (12) send_circle(rand_coord(), rand_coord(), 5'd31, 16'($urandom));

      // sender pauses until every span is out
      req_tvalid <= 1'b0;
      wait_for_drain();

      send_random_circles(150);
      idle_on = 1'b1;
      send_random_circles(150);
      req_tvalid <= 1'b0;

      wait_for_drain();
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filled_circle_span_generator.f =====
rtl/core/fcsg_pkg.sv
rtl/core/fcsg_front.sv
rtl/core/fcsg_queue.sv
rtl/core/fcsg_back.sv
rtl/core/filled_circle_span_generator.sv
sim/fcsg_span_checker.sv
sim/tb_filled_circle_span_generator.sv
